// ----- src/sxc_pkg.sv -----
// Types and constants shared by the s-expression syntax checker.
`default_nettype none
package sxc_pkg;

  localparam int unsigned DEPTH_OUT_W = 9;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  // Register index (paddr[2])
  localparam logic REG_MAX_ID_LENGTH = 1'b0;

  localparam logic [5:0] MAX_ID_LENGTH_RESET = 6'd32;

  // Result status codes
  localparam logic [3:0] ST_SCAN      = 4'd0;
  localparam logic [3:0] ST_COMPLETE  = 4'd1;
  localparam logic [3:0] ST_IGNORED   = 4'd2;
  localparam logic [3:0] ST_TOO_LONG  = 4'd3;
  localparam logic [3:0] ST_BAD_ID    = 4'd4;
  localparam logic [3:0] ST_NOT_DIGIT = 4'd5;
  localparam logic [3:0] ST_BAD_STR   = 4'd6;
  localparam logic [3:0] ST_UNMATCHED = 4'd7;
  localparam logic [3:0] ST_OVERFLOW  = 4'd8;
  localparam logic [3:0] ERR_NONE     = ST_SCAN;

  // Byte values
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CH_TILDE   = 8'h7E;

  typedef enum logic [2:0] {
    MODE_BETWEEN  = 3'd0,
    MODE_STR_LEAD = 3'd1,
    MODE_STR_BODY = 3'd2,
    MODE_ID       = 3'd3,
    MODE_NUM      = 3'd4,
    MODE_DONE     = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [3:0]             status;
    logic [31:0]            byte_index;
    logic [31:0]            error_index;
    logic [7:0]             error_byte;
    logic [DEPTH_OUT_W-1:0] nesting_depth;
  } result_t;

endpackage
`default_nettype wire

// ----- src/sexpr_syntax_checker.sv -----
// Top level of the s-expression syntax checker.
// Takes one source byte per transaction and returns one result per byte, at up to one
// byte per clock: each byte is decided combinationally from the registered parse state,
// and its result is registered in the output register or the skid entry. A two-entry output
// buffer keeps bytes flowing while a result waits; input stalls only when both are full.
// The kind of the innermost open list sits in a flop; outer kinds live in a STACK_DEPTH x 1
// RAM whose registered read always points at the entry just below the innermost one.
// No clearing pass after reset is needed. max_id_length is written over the APB port at
// byte address 0; the user must write it only while idle, which the block does not enforce.
`default_nettype none
module sexpr_syntax_checker #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         byte_valid,
  output logic                              byte_ready,
  input  wire sxc_pkg::item_t               byte_item,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output sxc_pkg::result_t                  result_item,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sxc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sxc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sxc_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  // Parse state
  sxc_pkg::mode_t mode, mode_next;
  logic [DW-1:0]  depth, depth_next;
  logic [5:0]     id_len, id_len_next;
  logic [31:0]    pos;
  logic [3:0]     err_code;
  logic [31:0]    err_index;
  logic [7:0]     err_byte;
  logic           top_kind;
  logic           byp_valid;
  logic           byp_kind;
  logic [5:0]     max_id_length;

  // Output buffer
  logic             skid_valid;
  sxc_pkg::result_t skid_item;
  sxc_pkg::result_t new_item;

  // Effective state for the byte being taken (restart clears it)
  sxc_pkg::mode_t cur_mode;
  logic [DW-1:0]  cur_depth;
  logic [5:0]     cur_id_len;
  logic [31:0]    cur_pos;
  logic [3:0]     cur_err;
  logic [31:0]    cur_err_index;
  logic [7:0]     cur_err_byte;

  logic       acc;
  logic [7:0] b;
  logic       is_blank, is_open, is_close, close_kind, close_ok, is_digit, is_quote;
  logic       id_ok, printable, at_full;
  sxc_pkg::mode_t fin_mode;
  logic [3:0] raise, status;
  logic       push, pop;
  logic       below;

  logic          wr_en;
  logic [DW-1:0] depth_m1, d_after, d_after_m2;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          rd_kind;

  assign acc = byte_valid && byte_ready;
  assign b   = byte_item.data_byte;

  assign cur_mode      = byte_item.restart ? sxc_pkg::MODE_BETWEEN : mode;
  assign cur_depth     = byte_item.restart ? '0 : depth;
  assign cur_id_len    = byte_item.restart ? '0 : id_len;
  assign cur_pos       = byte_item.restart ? '0 : pos;
  assign cur_err       = byte_item.restart ? sxc_pkg::ERR_NONE : err_code;
  assign cur_err_index = byte_item.restart ? '0 : err_index;
  assign cur_err_byte  = byte_item.restart ? '0 : err_byte;

  // Byte classes
  assign is_blank   = (b == sxc_pkg::CH_SPACE) || (b == sxc_pkg::CH_NEWLINE);
  assign is_open    = (b == sxc_pkg::CH_LPAREN) || (b == sxc_pkg::CH_LBRACK);
  assign is_close   = (b == sxc_pkg::CH_RPAREN) || (b == sxc_pkg::CH_RBRACK);
  assign close_kind = (b == sxc_pkg::CH_RBRACK);
  assign is_quote   = (b == sxc_pkg::CH_QUOTE);
  assign is_digit   = (b >= sxc_pkg::CH_ZERO) && (b <= sxc_pkg::CH_NINE);
  assign id_ok      = (b >= sxc_pkg::CH_PLUS) && (b <= sxc_pkg::CH_LOW_Z) &&
                      (b != sxc_pkg::CH_COLON) && (b != sxc_pkg::CH_LBRACK);
  assign printable  = (b >= sxc_pkg::CH_SPACE) && (b <= sxc_pkg::CH_TILDE);
  assign close_ok   = (cur_depth != '0) && (top_kind == close_kind);
  assign at_full    = (cur_depth == DW'(STACK_DEPTH));
  assign fin_mode   = (cur_depth == '0) ? sxc_pkg::MODE_DONE : sxc_pkg::MODE_BETWEEN;

  // Next scan mode
  always_comb begin
    mode_next = cur_mode;
    if (cur_err == sxc_pkg::ERR_NONE) begin
      unique case (cur_mode)
        sxc_pkg::MODE_BETWEEN: begin
          if (is_close) begin
            if (close_ok && (cur_depth == DW'(1))) mode_next = sxc_pkg::MODE_DONE;
          end else if (is_quote) begin
            mode_next = sxc_pkg::MODE_STR_LEAD;
          end else if (is_digit) begin
            mode_next = sxc_pkg::MODE_NUM;
          end else if (!is_blank && !is_open) begin
            mode_next = sxc_pkg::MODE_ID;
          end
        end
        sxc_pkg::MODE_STR_LEAD: begin
          if (!is_blank) mode_next = is_quote ? fin_mode : sxc_pkg::MODE_STR_BODY;
        end
        sxc_pkg::MODE_STR_BODY: begin
          if (is_quote) mode_next = fin_mode;
        end
        sxc_pkg::MODE_ID, sxc_pkg::MODE_NUM: begin
          if (is_blank) begin
            mode_next = fin_mode;
          end else if (is_close) begin
            mode_next = ((cur_depth == '0) || (close_ok && (cur_depth == DW'(1)))) ?
                        sxc_pkg::MODE_DONE : sxc_pkg::MODE_BETWEEN;
          end
        end
        default: mode_next = cur_mode;
      endcase
    end
  end

  // Errors, stack moves and identifier length
  always_comb begin
    raise       = sxc_pkg::ERR_NONE;
    push        = 1'b0;
    pop         = 1'b0;
    id_len_next = cur_id_len;
    if (cur_err == sxc_pkg::ERR_NONE) begin
      unique case (cur_mode)
        sxc_pkg::MODE_BETWEEN: begin
          if (is_open) begin
            if (at_full) raise = sxc_pkg::ST_OVERFLOW;
            else push = 1'b1;
          end else if (is_close) begin
            if (close_ok) pop = 1'b1;
            else raise = sxc_pkg::ST_UNMATCHED;
          end else if (!is_blank && !is_quote && !is_digit) begin
            id_len_next = '0;
            priority if (max_id_length == '0) raise = sxc_pkg::ST_TOO_LONG;
            else if (!id_ok) raise = sxc_pkg::ST_BAD_ID;
            else id_len_next = 6'd1;
          end
        end
        sxc_pkg::MODE_STR_LEAD: begin
          if (!is_blank && !is_quote && !printable) raise = sxc_pkg::ST_BAD_STR;
        end
        sxc_pkg::MODE_STR_BODY: begin
          if (!is_quote && !printable) raise = sxc_pkg::ST_BAD_STR;
        end
        sxc_pkg::MODE_ID: begin
          if (is_close) begin
            if (cur_depth != '0) begin
              if (close_ok) pop = 1'b1;
              else raise = sxc_pkg::ST_UNMATCHED;
            end
          end else if (!is_blank) begin
            priority if (cur_id_len >= max_id_length) raise = sxc_pkg::ST_TOO_LONG;
            else if (!id_ok) raise = sxc_pkg::ST_BAD_ID;
            else id_len_next = cur_id_len + 6'd1;
          end
        end
        sxc_pkg::MODE_NUM: begin
          if (is_close) begin
            if (cur_depth != '0) begin
              if (close_ok) pop = 1'b1;
              else raise = sxc_pkg::ST_UNMATCHED;
            end
          end else if (!is_blank && !is_digit) begin
            raise = sxc_pkg::ST_NOT_DIGIT;
          end
        end
        default: raise = sxc_pkg::ERR_NONE;
      endcase
    end
  end

  always_comb begin
    priority if (cur_err != sxc_pkg::ERR_NONE) status = cur_err;
    else if (cur_mode == sxc_pkg::MODE_DONE) status = sxc_pkg::ST_IGNORED;
    else if (raise != sxc_pkg::ERR_NONE) status = raise;
    else if (mode_next == sxc_pkg::MODE_DONE) status = sxc_pkg::ST_COMPLETE;
    else status = sxc_pkg::ST_SCAN;
  end

  assign depth_next = push ? cur_depth + DW'(1) : (pop ? cur_depth - DW'(1) : cur_depth);

  always_comb begin
    new_item.status        = status;
    new_item.byte_index    = cur_pos;
    new_item.error_index   = (raise != sxc_pkg::ERR_NONE) ? cur_pos : cur_err_index;
    new_item.error_byte    = (raise != sxc_pkg::ERR_NONE) ? b : cur_err_byte;
    new_item.nesting_depth = sxc_pkg::DEPTH_OUT_W'(depth_next);
  end

  // Bracket stack below the innermost entry
  assign depth_m1   = cur_depth - DW'(1);
  assign wr_addr    = depth_m1[AW-1:0];
  assign wr_en      = acc && push && (cur_depth != '0);
  assign d_after    = acc ? depth_next : depth;
  assign d_after_m2 = d_after - DW'(2);
  assign rd_addr    = d_after_m2[AW-1:0];
  assign below      = byp_valid ? byp_kind : rd_kind;

  sxc_ram #(
    .WIDTH (1),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top_kind),
    .rd_addr (rd_addr),
    .rd_data (rd_kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= sxc_pkg::MODE_BETWEEN;
      depth     <= '0;
      id_len    <= '0;
      pos       <= '0;
      err_code  <= sxc_pkg::ERR_NONE;
      err_index <= '0;
      err_byte  <= '0;
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= wr_en && (wr_addr == rd_addr);
      if (acc) begin
        mode      <= mode_next;
        depth     <= depth_next;
        id_len    <= id_len_next;
        pos       <= cur_pos + 32'd1;
        err_code  <= (raise != sxc_pkg::ERR_NONE) ? raise : cur_err;
        err_index <= new_item.error_index;
        err_byte  <= new_item.error_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_kind <= top_kind;
    if (acc && push) begin
      top_kind <= (b == sxc_pkg::CH_LBRACK);
    end else if (acc && pop) begin
      top_kind <= below;
    end
  end

  // Output register plus skid entry
  assign byte_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= acc;
      end
    end else if (acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      result_item <= skid_valid ? skid_item : new_item;
    end else if (acc) begin
      skid_item <= new_item;
    end
  end

  // Configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sxc_pkg::REG_MAX_ID_LENGTH) ?
                  sxc_pkg::PDATA_W'(max_id_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_id_length <= sxc_pkg::MAX_ID_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == sxc_pkg::REG_MAX_ID_LENGTH)) begin
      max_id_length <= pwdata[5:0];
    end
  end

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    acc && !byte_item.restart && (err_code != sxc_pkg::ERR_NONE)
    |=> err_code == $past(err_code))
    else $error("latched error changed without restart");

  a_depth_step: assert property (@(posedge clk) disable iff (rst)
    acc && !byte_item.restart
    |=> (depth == $past(depth)) || (depth == $past(depth) + DW'(1)) ||
        (depth == $past(depth) - DW'(1)))
    else $error("nesting depth moved by more than one");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(depth) && $stable(mode) && $stable(err_code))
    else $error("parse state changed without a transaction");
`endif

endmodule
`default_nettype wire

// ----- src/sxc_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sxc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
